@@ rtl/gasa_pkg.sv @@
package gasa_pkg;

  // widths fixed by the item fields
  localparam int unsigned CODE_W = 16;
  localparam int unsigned GLYPH_W = 9;
  localparam int unsigned PAD_W = 8;
  localparam int unsigned LH_W = 10;
  localparam int unsigned U_W = 10;
  localparam int unsigned V_W = 9;
  localparam int unsigned SIZE_W = 10;
  localparam int unsigned PAGE_W = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 10;

  // saturation limits
  localparam logic [U_W-1:0] X_MAX = 10'h3FF;
  localparam logic [PAGE_W-1:0] PAGE_MAX = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_PADDING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic [LH_W-1:0]  line_h;
  } cfg_t;

  // classified request, front to back
  typedef struct packed {
    logic               query;
    logic [CODE_W-1:0]  slot;
    logic               has_bm;
    logic [GLYPH_W-1:0] gw;
    logic [GLYPH_W-1:0] gh;
  } cmd_t;

  // one placement table entry
  typedef struct packed {
    logic [U_W-1:0]    u;
    logic [V_W-1:0]    v;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [PAGE_W-1:0] page;
  } entry_t;

  typedef struct packed {
    logic   found;
    logic   newly;
    entry_t ent;
  } res_t;

endpackage

@@ rtl/glyph_atlas_shelf_allocator_core.sv @@
// Channel   Direction  Handshake           Payload
// request   in         push / full         req_type_i, char_code_i, has_bitmap_i,
//                                          glyph_width_i, glyph_height_i
// result    out        empty / pop         found_o, newly_placed_o, tex_u_o, tex_v_o,
//                                          cell_width_o, cell_height_o, page_index_o
// config    in         cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// Each beat passes a registered front stage (slot reduction), then the back: a
// table read in its idle step, then pack, write back and post the result in its
// execute step. The back takes no new beat before it has posted the last one.
// After reset the back sweeps the table, one entry a cycle, over all CODE_COUNT entries;
// full stays high for the whole sweep.
// A stalled result queue holds the back in its execute step; the command queue
// lets the front take up to three further beats meanwhile.
module glyph_atlas_shelf_allocator_core #(
  parameter int unsigned PAGE_WIDTH = 512,
  parameter int unsigned PAGE_HEIGHT = 512,
  parameter int unsigned CODE_COUNT = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request queue
  input  logic                                push,
  output logic                                full,
  input  logic                                req_type_i,
  input  logic [gasa_pkg::CODE_W-1:0]         char_code_i,
  input  logic                                has_bitmap_i,
  input  logic [gasa_pkg::GLYPH_W-1:0]        glyph_width_i,
  input  logic [gasa_pkg::GLYPH_W-1:0]        glyph_height_i,
  // result queue
  output logic                                empty,
  input  logic                                pop,
  output logic                                found_o,
  output logic                                newly_placed_o,
  output logic [gasa_pkg::U_W-1:0]            tex_u_o,
  output logic [gasa_pkg::V_W-1:0]            tex_v_o,
  output logic [gasa_pkg::SIZE_W-1:0]         cell_width_o,
  output logic [gasa_pkg::SIZE_W-1:0]         cell_height_o,
  output logic [gasa_pkg::PAGE_W-1:0]         page_index_o,
  // config writes
  input  logic                                cfg_we_i,
  input  logic [gasa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gasa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CMD_W = $bits(gasa_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(gasa_pkg::res_t);

  gasa_pkg::cfg_t cfg_q, cfg_d;

  logic           front_ready, front_push;
  logic           front_valid, cmdq_full, cmdq_empty;
  gasa_pkg::cmd_t front_cmd, back_cmd;
  logic           cmd_pop, res_push, resq_full, clearing;
  gasa_pkg::res_t back_res, out_res;

  // config registers; writes must land only while the block is idle (not enforced here)
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        gasa_pkg::CFG_GLYPH_PADDING: cfg_d.pad    = cfg_wdata_i[gasa_pkg::PAD_W-1:0];
        gasa_pkg::CFG_LINE_HEIGHT:   cfg_d.line_h = cfg_wdata_i[gasa_pkg::LH_W-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // no beats taken during the table sweep
  assign full       = !front_ready || clearing;
  assign front_push = push && !full;

  gasa_front #(
    .CODE_COUNT (CODE_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (front_push),
    .in_ready_o     (front_ready),
    .req_type_i     (req_type_i),
    .char_code_i    (char_code_i),
    .has_bitmap_i   (has_bitmap_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .cmd_valid_o    (front_valid),
    .cmd_ready_i    (!cmdq_full),
    .cmd_o          (front_cmd)
  );

  gasa_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .full_o  (cmdq_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmdq_empty)
  );

  gasa_back #(
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT),
    .CODE_COUNT  (CODE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmdq_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!resq_full),
    .res_push_o  (res_push),
    .res_o       (back_res),
    .clearing_o  (clearing)
  );

  // result skid queue, decouples the back from the consumer
  gasa_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (resq_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign found_o        = out_res.found;
  assign newly_placed_o = out_res.newly;
  assign tex_u_o        = out_res.ent.u;
  assign tex_v_o        = out_res.ent.v;
  assign cell_width_o   = out_res.ent.w;
  assign cell_height_o  = out_res.ent.h;
  assign page_index_o   = out_res.ent.page;

endmodule

@@ rtl/gasa_ram.sv @@
module gasa_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gasa_fifo.sv @@
module gasa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/gasa_front.sv @@
module gasa_front #(
  parameter int unsigned CODE_COUNT = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [gasa_pkg::CODE_W-1:0]      char_code_i,
  input  logic                             has_bitmap_i,
  input  logic [gasa_pkg::GLYPH_W-1:0]     glyph_width_i,
  input  logic [gasa_pkg::GLYPH_W-1:0]     glyph_height_i,
  output logic                             cmd_valid_o,
  input  logic                             cmd_ready_i,
  output gasa_pkg::cmd_t                   cmd_o
);

  // slot = code mod CODE_COUNT by reciprocal multiply; floor is exact for 16-bit codes
  localparam int unsigned RW = 25;
  localparam int unsigned PROD_W = gasa_pkg::CODE_W + RW;
  localparam int unsigned QW = PROD_W - 32;
  localparam int unsigned SW = gasa_pkg::CODE_W + 1;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << 32) / 64'(CODE_COUNT) + 64'd1);
  localparam logic [SW-1:0] CC = SW'(CODE_COUNT);

  logic                         s1_valid_q, s1_valid_d;
  logic                         query_q;
  logic [gasa_pkg::CODE_W-1:0]  code_q;
  logic                         has_bm_q;
  logic [gasa_pkg::GLYPH_W-1:0] gw_q, gh_q;
  logic [QW-1:0]                quo_q;
  logic [PROD_W-1:0]            prod;
  logic [QW+SW-1:0]             qc;
  logic [SW-1:0]                rem;
  logic                         in_fire;

  assign in_ready_o = !s1_valid_q || cmd_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign prod       = PROD_W'(char_code_i) * PROD_W'(RECIP);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      query_q  <= req_type_i;
      code_q   <= char_code_i;
      has_bm_q <= has_bitmap_i;
      gw_q     <= glyph_width_i;
      gh_q     <= glyph_height_i;
      quo_q    <= prod[PROD_W-1:32];
    end
  end

  assign qc  = (QW + SW)'(quo_q) * (QW + SW)'(CC);
  assign rem = {1'b0, code_q} - qc[SW-1:0];

  assign cmd_valid_o   = s1_valid_q;
  assign cmd_o.query   = query_q;
  assign cmd_o.slot    = rem[gasa_pkg::CODE_W-1:0];
  assign cmd_o.has_bm  = has_bm_q;
  assign cmd_o.gw      = gw_q;
  assign cmd_o.gh      = gh_q;

  a_fire_loads_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted beat did not reach the slot stage");

endmodule

@@ rtl/gasa_back.sv @@
module gasa_back #(
  parameter int unsigned PAGE_WIDTH = 512,
  parameter int unsigned PAGE_HEIGHT = 512,
  parameter int unsigned CODE_COUNT = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gasa_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  gasa_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_ready_i,
  output logic           res_push_o,
  output gasa_pkg::res_t res_o,
  output logic           clearing_o
);

  localparam int unsigned AW = $clog2(CODE_COUNT);
  localparam int unsigned EW = $bits(gasa_pkg::entry_t);
  localparam logic [10:0] PW11 = 11'(PAGE_WIDTH);
  localparam logic [11:0] PH12 = 12'(PAGE_HEIGHT);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 clr_addr_q, clr_addr_d;
  gasa_pkg::cmd_t                cmd_q;
  logic [gasa_pkg::U_W-1:0]      cursor_x_q, cursor_x_d;
  logic [gasa_pkg::V_W-1:0]      cursor_y_q, cursor_y_d;
  logic [gasa_pkg::SIZE_W-1:0]   shelf_q, shelf_d;
  logic [gasa_pkg::PAGE_W-1:0]   page_q, page_d;

  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr;
  logic [EW:0]                   ram_wdata, ram_rdata;

  logic                          rd_valid, place, exec_fire;
  gasa_pkg::entry_t              rd_ent, new_ent;
  logic [gasa_pkg::SIZE_W-1:0]   w, h, shelf_a, shelf_n;
  logic                          grow, wrap, pfull;
  logic [10:0]                   xw_sum, y_sum, x_sum;
  logic [11:0]                   y_chk;
  logic [gasa_pkg::U_W-1:0]      x_base, x_next;
  logic [gasa_pkg::V_W-1:0]      y_base;
  logic [gasa_pkg::PAGE_W-1:0]   page_n;

  gasa_ram #(
    .WIDTH (EW + 1),
    .DEPTH (CODE_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cmd_i.slot[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign clearing_o = (state_q == ST_CLEAR);
  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign ram_re     = cmd_pop_o;
  assign exec_fire  = (state_q == ST_EXEC) && res_ready_i;
  assign res_push_o = exec_fire;

  // shelf packing for the entry read from the table in the idle step
  always_comb begin
    rd_valid = ram_rdata[EW];
    rd_ent   = gasa_pkg::entry_t'(ram_rdata[EW-1:0]);
    place    = !rd_valid && !cmd_q.query;

    w       = gasa_pkg::SIZE_W'(cmd_q.gw) + gasa_pkg::SIZE_W'(cfg_i.pad);
    h       = gasa_pkg::SIZE_W'(cmd_q.gh) + gasa_pkg::SIZE_W'(cfg_i.pad);
    grow    = {1'b0, cmd_q.gh} > shelf_q;
    shelf_a = grow ? gasa_pkg::SIZE_W'(cmd_q.gh) + gasa_pkg::SIZE_W'(1) : shelf_q;
    xw_sum  = 11'(cursor_x_q) + 11'(w);
    wrap    = xw_sum > PW11;
    y_sum   = 11'(cursor_y_q) + 11'(shelf_a);
    y_chk   = 12'(y_sum) + 12'(cfg_i.line_h);
    pfull   = y_chk >= PH12;

    x_base  = cursor_x_q;
    y_base  = cursor_y_q;
    shelf_n = shelf_a;
    page_n  = page_q;
    if (wrap) begin
      x_base  = '0;
      shelf_n = '0;
      if (pfull) begin
        y_base = '0;
        page_n = (page_q != gasa_pkg::PAGE_MAX) ? page_q + gasa_pkg::PAGE_W'(1) : page_q;
      end else begin
        y_base = y_sum[gasa_pkg::V_W-1:0];
      end
    end

    // glyphs without a bitmap only nudge x by one
    if (cmd_q.has_bm) begin
      x_sum = 11'(x_base) + 11'(w) + 11'd1;
    end else begin
      x_sum = 11'(cursor_x_q) + 11'd1;
    end
    x_next = (x_sum > 11'(gasa_pkg::X_MAX)) ? gasa_pkg::X_MAX : x_sum[gasa_pkg::U_W-1:0];

    new_ent = '0;
    if (cmd_q.has_bm) begin
      new_ent.u    = x_base;
      new_ent.v    = y_base;
      new_ent.w    = w;
      new_ent.h    = h;
      new_ent.page = page_n;
    end

    res_o.found = rd_valid || place;
    res_o.newly = place;
    if (place) begin
      res_o.ent = new_ent;
    end else if (rd_valid) begin
      res_o.ent = rd_ent;
    end else begin
      res_o.ent = '0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd_q.slot[AW-1:0];
    ram_wdata = {1'b1, new_ent};
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (exec_fire && place) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    shelf_d    = shelf_q;
    page_d     = page_q;
    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(CODE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_pop_o) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
          if (place) begin
            cursor_x_d = x_next;
            if (cmd_q.has_bm) begin
              cursor_y_d = y_base;
              shelf_d    = shelf_n;
              page_d     = page_n;
            end
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      shelf_q    <= '0;
      page_q     <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      shelf_q    <= shelf_d;
      page_q     <= page_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  a_pop_then_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == ST_EXEC))
    else $error("popped command not executed next cycle");

  a_place_moves_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && place) |=> (cursor_x_q != '0))
    else $error("placement left the x cursor at zero");

  a_page_monotone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_q >= $past(page_q))
    else $error("current page went backwards");

endmodule

@@ verif/glyph_atlas_shelf_allocator_core_tb.sv @@
module glyph_atlas_shelf_allocator_core_tb;

  // geometry matches the block's default parameters
  localparam int unsigned PAGE_WIDTH = 512;
  localparam int unsigned PAGE_HEIGHT = 512;
  // no-acceptance limit: covers the post-reset table sweep (all 65536 entries, with
  // full held high) several times over, and the long result hold-off
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  // front stage plus the back's read and execute steps, with some slack
  localparam int unsigned DRAIN_SLACK = 8;
  localparam int unsigned REPORT_MAX = 10;

  // an awaited result beat, tagged with its code for the reports
  typedef struct {
    logic [gasa_pkg::CODE_W-1:0] code;
    gasa_pkg::res_t              res;
  } awaited_t;

  // Tracks the shelf packer and the placement table, and holds the result
  // beats still to come, oldest first.
  class atlas_placement_tracker;
    gasa_pkg::entry_t placed[logic [gasa_pkg::CODE_W-1:0]];
    awaited_t         awaited[$];
    int unsigned      pad;
    int unsigned      line_h;
    int unsigned      cur_x;
    int unsigned      cur_y;
    int unsigned      shelf_h;
    int unsigned      cur_page;
    int unsigned      failures;

    function new();
      pad = 0;
      line_h = 0;
      cur_x = 0;
      cur_y = 0;
      shelf_h = 0;
      cur_page = 0;
      failures = 0;
    endfunction

    function void set_layout(logic [gasa_pkg::CFG_DATA_W-1:0] pad_val,
                             logic [gasa_pkg::CFG_DATA_W-1:0] lh_val);
      pad = pad_val[gasa_pkg::PAD_W-1:0];  // upper data bits are dropped
      line_h = lh_val;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // accepted request beat: update the packer, queue the answer
    function void note_request(gasa_pkg::cmd_t req);
      awaited_t         want;
      gasa_pkg::entry_t ent;
      int unsigned      w;
      int unsigned      h;
      want.code = req.slot;
      want.res = '0;
      if (!placed.exists(req.slot) && !req.query) begin
        ent = '0;
        if (req.has_bm) begin
          w = int'(req.gw) + pad;
          h = int'(req.gh) + pad;
          // shelf grows to the raw bitmap height plus one
          if (req.gh > shelf_h) shelf_h = int'(req.gh) + 1;
          if (cur_x + w > PAGE_WIDTH) begin
            cur_y += shelf_h;
            shelf_h = 0;
            cur_x = 0;
            if (cur_y + line_h >= PAGE_HEIGHT) begin
              cur_y = 0;
              if (cur_page < gasa_pkg::PAGE_MAX) cur_page++;
            end
          end
          ent.u = gasa_pkg::U_W'(cur_x);
          ent.v = gasa_pkg::V_W'(cur_y);
          ent.w = gasa_pkg::SIZE_W'(w);
          ent.h = gasa_pkg::SIZE_W'(h);
          ent.page = gasa_pkg::PAGE_W'(cur_page);
          cur_x = (cur_x + w + 1 > gasa_pkg::X_MAX) ? gasa_pkg::X_MAX : cur_x + w + 1;
        end else begin
          // no bitmap: empty entry, cursor steps by one
          cur_x = (cur_x + 1 > gasa_pkg::X_MAX) ? gasa_pkg::X_MAX : cur_x + 1;
        end
        placed[req.slot] = ent;
        want.res.newly = 1'b1;
      end
      if (placed.exists(req.slot)) begin
        want.res.found = 1'b1;
        want.res.ent = placed[req.slot];
      end
      awaited.push_back(want);
    endfunction

    // accepted result beat: compare with the oldest awaited one
    function void check_result(gasa_pkg::res_t got);
      awaited_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%0t: result beat with nothing awaited: found %b new %b",
                   $time, got.found, got.newly);
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.res.found || got.newly !== want.res.newly ||
          got.ent.u !== want.res.ent.u || got.ent.v !== want.res.ent.v ||
          got.ent.w !== want.res.ent.w || got.ent.h !== want.res.ent.h ||
          got.ent.page !== want.res.ent.page) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("%0t: code %h exp found %b new %b u %0d v %0d w %0d h %0d pg %0d",
                   $time, want.code, want.res.found, want.res.newly, want.res.ent.u,
                   want.res.ent.v, want.res.ent.w, want.res.ent.h, want.res.ent.page);
          $display("%0t: code %h got found %b new %b u %0d v %0d w %0d h %0d pg %0d",
                   $time, want.code, got.found, got.newly, got.ent.u, got.ent.v,
                   got.ent.w, got.ent.h, got.ent.page);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            push = 1'b0;
  logic                            full;
  logic                            req_type = 1'b0;
  logic [gasa_pkg::CODE_W-1:0]     char_code = '0;
  logic                            has_bitmap = 1'b0;
  logic [gasa_pkg::GLYPH_W-1:0]    glyph_width = '0;
  logic [gasa_pkg::GLYPH_W-1:0]    glyph_height = '0;
  logic                            empty;
  logic                            pop = 1'b0;
  logic                            found;
  logic                            newly_placed;
  logic [gasa_pkg::U_W-1:0]        tex_u;
  logic [gasa_pkg::V_W-1:0]        tex_v;
  logic [gasa_pkg::SIZE_W-1:0]     cell_width;
  logic [gasa_pkg::SIZE_W-1:0]     cell_height;
  logic [gasa_pkg::PAGE_W-1:0]     page_index;
  logic                            cfg_we = 1'b0;
  logic [gasa_pkg::CFG_IDX_W-1:0]  cfg_idx = gasa_pkg::CFG_GLYPH_PADDING;
  logic [gasa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  atlas_placement_tracker tracker;

  // stimulus bookkeeping: which codes have had a place request sent
  bit                          placed_mark[logic [gasa_pkg::CODE_W-1:0]];
  logic [gasa_pkg::CODE_W-1:0] placed_codes[$];
  int unsigned                 burst_left = 0;
  // set by the stimulus, served and cleared by the result sink
  bit                          hold_off_req = 1'b0;
  int unsigned                 idle_cycles = 0;

  glyph_atlas_shelf_allocator_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type),
    .char_code_i    (char_code),
    .has_bitmap_i   (has_bitmap),
    .glyph_width_i  (glyph_width),
    .glyph_height_i (glyph_height),
    .empty          (empty),
    .pop            (pop),
    .found_o        (found),
    .newly_placed_o (newly_placed),
    .tex_u_o        (tex_u),
    .tex_v_o        (tex_v),
    .cell_width_o   (cell_width),
    .cell_height_o  (cell_height),
    .page_index_o   (page_index),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor: every accepted beat on either side goes through the tracker.
  // Sampling at the rising edge sees the pre-edge values, as the block does.
  always @(posedge clk) begin : beat_monitor
    gasa_pkg::res_t got;
    gasa_pkg::cmd_t req;
    if (rst_n) begin
      if (pop && !empty) begin
        got.found = found;
        got.newly = newly_placed;
        got.ent.u = tex_u;
        got.ent.v = tex_v;
        got.ent.w = cell_width;
        got.ent.h = cell_height;
        got.ent.page = page_index;
        tracker.check_result(got);
      end
      if (push && !full) begin
        req.query = req_type;
        req.slot = char_code;  // table covers every code, so slot == code
        req.has_bm = has_bitmap;
        req.gw = glyph_width;
        req.gh = glyph_height;
        tracker.note_request(req);
      end
    end
    // watchdog: cycles without a beat on either side
    if ((pop && !empty) || (push && !full)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink: stalls on a changing duty pattern, with the odd spell of
  // always popping. A hold-off request parks pop low for a long stretch.
  initial begin : result_sink
    int unsigned pattern_left;
    int unsigned stall_pct;
    int unsigned held;
    pattern_left = 0;
    stall_pct = 0;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        pop <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) begin
          hold_off_req = 1'b0;
          held = 0;
        end
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 120);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pattern_left--;
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Drive one request beat and return at the edge that took it. Bursts of
  // random length are broken by random gaps; push stays high within a burst.
  task automatic offer(input bit query, input logic [gasa_pkg::CODE_W-1:0] code,
                       input bit bm, input int unsigned gw, input int unsigned gh);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (!query && !placed_mark.exists(code)) begin
      placed_mark[code] = 1'b1;
      placed_codes.push_back(code);
    end
    push <= 1'b1;
    req_type <= query;
    char_code <= code;
    has_bitmap <= bm;
    glyph_width <= gasa_pkg::GLYPH_W'(gw);
    glyph_height <= gasa_pkg::GLYPH_W'(gh);
    do @(posedge clk); while (full);
  endtask

  // Stop sending and wait until every awaited beat has come back; the
  // tracker is read at the falling edge, clear of the monitor's updates.
  task automatic pause_for_results();
    push <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (tracker.outstanding() != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Writes both registers on back-to-back edges; only called with no request in flight.
  task automatic set_layout(input logic [gasa_pkg::CFG_DATA_W-1:0] pad_val,
                            input logic [gasa_pkg::CFG_DATA_W-1:0] lh_val);
    cfg_we <= 1'b1;
    cfg_idx <= gasa_pkg::CFG_GLYPH_PADDING;
    cfg_wdata <= pad_val;
    @(posedge clk);
    cfg_idx <= gasa_pkg::CFG_LINE_HEIGHT;
    cfg_wdata <= lh_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_layout(pad_val, lh_val);
  endtask

  function automatic logic [gasa_pkg::CODE_W-1:0] fresh_code();
    logic [gasa_pkg::CODE_W-1:0] code;
    do code = gasa_pkg::CODE_W'($urandom_range(0, 65535));
    while (placed_mark.exists(code));
    return code;
  endfunction

  function automatic logic [gasa_pkg::CODE_W-1:0] known_code();
    if (placed_codes.size() == 0) return gasa_pkg::CODE_W'($urandom_range(0, 65535));
    return placed_codes[$urandom_range(0, placed_codes.size() - 1)];
  endfunction

  // glyph sizes lean to the small and the page-filling ends
  function automatic int unsigned glyph_dim();
    case ($urandom_range(0, 4))
      0, 1: return $urandom_range(0, 31);
      2: return $urandom_range(480, 511);
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // One random phase: settle, set the layout, then mostly new placements,
  // with repeats, queries of known codes and queries of arbitrary codes.
  task automatic random_phase(input logic [gasa_pkg::CFG_DATA_W-1:0] pad_val,
                              input logic [gasa_pkg::CFG_DATA_W-1:0] lh_val,
                              input int unsigned count, input int unsigned fresh_pct);
    int unsigned n;
    int unsigned roll;
    pause_for_results();
    set_layout(pad_val, lh_val);
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < fresh_pct)
        offer(1'b0, fresh_code(), $urandom_range(0, 9) != 0, glyph_dim(), glyph_dim());
      else if (roll < fresh_pct + (90 - fresh_pct) / 2)
        offer(1'b0, known_code(), 1'($urandom_range(0, 1)), glyph_dim(), glyph_dim());
      else if (roll < 90)
        offer(1'b1, known_code(), 1'($urandom_range(0, 1)), glyph_dim(), glyph_dim());
      else
        offer(1'b1, gasa_pkg::CODE_W'($urandom_range(0, 65535)),
              1'($urandom_range(0, 1)), glyph_dim(), glyph_dim());
    end
  endtask

  initial begin : stimulus
    int unsigned n;
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // -- directed: no padding, zero line height
    set_layout(10'd0, 10'd0);
    offer(1'b1, 16'h0000, 1'b1, 511, 511);  // query miss
    offer(1'b0, 16'hFFFF, 1'b1, 0, 0);      // empty bitmap, top code
    offer(1'b0, 16'hFFFF, 1'b1, 511, 511);  // known code returns stored entry
    offer(1'b1, 16'hFFFF, 1'b0, 0, 0);
    offer(1'b0, 16'h0000, 1'b0, 511, 511);  // missing bitmap, sizes ignored
    offer(1'b1, 16'h0000, 1'b1, 0, 0);
    offer(1'b0, 16'h8000, 1'b1, 511, 511);  // row wrap onto a new page
    offer(1'b0, 16'h0001, 1'b1, 511, 1);    // row wrap, short shelf
    offer(1'b0, 16'h5555, 1'b1, 9'h155, 9'h0AA);
    offer(1'b0, 16'hAAAA, 1'b1, 9'h0AA, 9'h155);
    offer(1'b1, 16'h5555, 1'b0, 0, 0);
    offer(1'b0, 16'h7FFF, 1'b1, 1, 511);
    offer(1'b1, 16'h1234, 1'b0, 511, 0);    // query miss

    // -- page and x saturation: wide padded glyphs wrap every row and, with
    //    full line height, open a page each time until the last one sticks;
    //    each leaves x at 767, so empty entries then pile up until x sticks
    //    at the top. Results are held off meanwhile so the block fills and
    //    pushes back on the request side.
    pause_for_results();
    set_layout(10'd255, 10'd1023);
    hold_off_req = 1'b1;
    for (n = 0; n < 260; n++)
      offer(1'b0, fresh_code(), 1'b1, 511, $urandom_range(0, 511));
    for (n = 0; n < 260; n++)
      offer(1'b0, fresh_code(), 1'b0, $urandom_range(0, 511), $urandom_range(0, 511));
    for (n = 0; n < 3; n++)
      offer(1'b0, fresh_code(), 1'b1, $urandom_range(0, 40), $urandom_range(0, 40));
    offer(1'b1, known_code(), 1'b0, 0, 0);

    // -- random phases; upper data bits on the padding write are dropped,
    //    and full line height makes every wrap ask for a new page
    random_phase(10'd3, 10'd16, 70, 55);
    random_phase(10'h3FF, 10'd1023, 85, 80);
    random_phase(gasa_pkg::CFG_DATA_W'($urandom_range(0, 255)), 10'd512, 60, 55);

    pause_for_results();
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gasa_pkg.sv
rtl/gasa_ram.sv
rtl/gasa_fifo.sv
rtl/gasa_front.sv
rtl/gasa_back.sv
rtl/glyph_atlas_shelf_allocator_core.sv
verif/glyph_atlas_shelf_allocator_core_tb.sv
